>>> hw/rtl/text_line_normalizer_assert.svh
// Assertion helpers shared by the line normalizer RTL.
// Each macro is sampled on clk and is off while rst_n is low.
`ifndef TEXT_LINE_NORMALIZER_ASSERT_SVH
`define TEXT_LINE_NORMALIZER_ASSERT_SVH

// Condition that must hold at every edge
`define TLN_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication
`define TLN_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define TLN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/tln_pkg.sv
`default_nettype none

package tln_pkg;

  // field widths
  localparam int BYTE_W = 8;
  localparam int LINE_W = 12;

  // longest line the hardware honors; larger limits are clamped to it
  localparam int MAX_LINE_LEN = 4095;
  localparam int LIM_MAX_INT  = (MAX_LINE_LEN > (2 ** LINE_W) - 1) ?
                                ((2 ** LINE_W) - 1) : MAX_LINE_LEN;
  localparam logic [LINE_W-1:0] LIM_MAX     = LIM_MAX_INT[LINE_W-1:0];
  localparam logic [LINE_W-1:0] LIMIT_RESET = 12'd4095;

  // characters of interest
  localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_BSL = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_SP  = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB = 8'h09;

  // what the previous byte left waiting
  typedef enum logic [1:0] {
    HELD_NONE = 2'd0,
    HELD_CR   = 2'd1,
    HELD_BSL  = 2'd2
  } held_kind_t;

  // one result, without its last flag
  typedef struct packed {
    logic [BYTE_W-1:0] byte_v;
    logic [LINE_W-1:0] spaces;
    logic              has;
    logic              eol;
  } res_t;

  // everything one byte produces: up to two results
  typedef struct packed {
    res_t       r0;
    res_t       r1;
    logic [1:0] n;
  } step_out_t;

endpackage

`default_nettype wire

>>> hw/rtl/tln_if.sv
`default_nettype none

// raw byte request channel
interface tln_in_if;
  import tln_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              end_of_stream;

  modport source (output valid, in_byte, end_of_stream, input ready);
  modport sink   (input valid, in_byte, end_of_stream, output ready);
endinterface

// normalized result channel
interface tln_out_if;
  import tln_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic [LINE_W-1:0] spaces_before;
  logic              has_byte;
  logic              end_of_line;
  logic              last_result;

  modport source (output valid, out_byte, spaces_before, has_byte, end_of_line,
                  last_result, input ready);
  modport sink   (input valid, out_byte, spaces_before, has_byte, end_of_line,
                  last_result, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/tln_step.sv
`default_nettype none

// Line state and the per-byte normalization logic.
// The join flag never outlives one byte (set and used by the same newline),
// so it needs no register.
module tln_step
  import tln_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              acc,
  input  wire logic [BYTE_W-1:0] in_byte,
  input  wire logic              end_of_stream,
  input  wire logic [LINE_W-1:0] line_limit,
  output step_out_t              step_out
);

  held_kind_t        held_r, held_nxt;
  logic              at_start_r, at_start_nxt;
  logic [LINE_W-1:0] stored_r, stored_nxt;
  logic [LINE_W-1:0] pend_r, pend_nxt;

  logic [LINE_W-1:0] lim;
  logic              is_nl;
  logic              bsl_plain;
  logic              join_nl;
  logic              swallow;
  logic              close_end;
  logic              blank;
  res_t              r0, r1;
  logic [1:0]        n;

  // effective limit: zero acts as one, large values are clamped
  always_comb begin
    if (line_limit == '0) begin
      lim = LINE_W'(1);
    end else if (line_limit > LIM_MAX) begin
      lim = LIM_MAX;
    end else begin
      lim = line_limit;
    end
  end

  assign is_nl     = (in_byte == CH_CR) || (in_byte == CH_LF);
  assign bsl_plain = (held_r == HELD_BSL) && (end_of_stream || !is_nl);
  assign join_nl   = (held_r == HELD_BSL) && !end_of_stream && is_nl;
  assign swallow   = !end_of_stream && (held_r == HELD_CR) && (in_byte == CH_LF);
  assign blank     = (in_byte == CH_SP) || (in_byte == CH_TAB);

  // one byte: held backslash first, then the byte itself, then a line close
  always_comb begin
    at_start_nxt = at_start_r;
    stored_nxt   = stored_r;
    pend_nxt     = pend_r;
    held_nxt     = HELD_NONE;
    r0           = '0;
    r1           = '0;
    n            = 2'd0;
    close_end    = 1'b0;

    // held backslash that did not join: an ordinary kept byte
    if (bsl_plain) begin
      at_start_nxt = 1'b0;
      r0.byte_v    = CH_BSL;
      r0.spaces    = pend_nxt;
      r0.has       = 1'b1;
      n            = 2'd1;
      pend_nxt     = '0;
      if (({1'b0, stored_nxt} + 13'd1) >= {1'b0, lim}) begin
        r0.eol       = 1'b1;
        at_start_nxt = 1'b1;
        stored_nxt   = '0;
      end else begin
        stored_nxt = stored_nxt + LINE_W'(1);
      end
    end

    if (end_of_stream) begin
      close_end = 1'b1;
    end else if (!swallow) begin
      if (is_nl) begin
        held_nxt = (in_byte == CH_CR) ? HELD_CR : HELD_NONE;
        if (join_nl) begin
          // joined newline becomes one stored space
          pend_nxt = pend_nxt + LINE_W'(1);
          if (({1'b0, stored_nxt} + 13'd1) >= {1'b0, lim}) begin
            close_end = 1'b1;
          end else begin
            stored_nxt = stored_nxt + LINE_W'(1);
          end
        end else begin
          close_end = 1'b1;
        end
      end else if (in_byte == CH_BSL) begin
        held_nxt = HELD_BSL;
      end else if (!(at_start_nxt && blank)) begin
        at_start_nxt = 1'b0;
        if (in_byte == CH_SP) begin
          pend_nxt = pend_nxt + LINE_W'(1);
        end else begin
          if (n == 2'd0) begin
            r0.byte_v = (in_byte == CH_TAB) ? CH_SP : in_byte;
            r0.spaces = pend_nxt;
            r0.has    = 1'b1;
            n         = 2'd1;
          end else begin
            r1.byte_v = (in_byte == CH_TAB) ? CH_SP : in_byte;
            r1.spaces = pend_nxt;
            r1.has    = 1'b1;
            n         = 2'd2;
          end
          pend_nxt = '0;
        end
        if (({1'b0, stored_nxt} + 13'd1) >= {1'b0, lim}) begin
          close_end = 1'b1;
        end else begin
          stored_nxt = stored_nxt + LINE_W'(1);
        end
      end
    end

    // close: mark the last open kept byte, else a bare line end
    if (close_end) begin
      if (n == 2'd2 && r1.has && !r1.eol) begin
        r1.eol = 1'b1;
      end else if (n == 2'd1 && r0.has && !r0.eol) begin
        r0.eol = 1'b1;
      end else if (n == 2'd0) begin
        r0.eol = 1'b1;
        n      = 2'd1;
      end else if (n == 2'd1) begin
        r1.eol = 1'b1;
        n      = 2'd2;
      end
      at_start_nxt = 1'b1;
      stored_nxt   = '0;
      pend_nxt     = '0;
    end
  end

  assign step_out.r0 = r0;
  assign step_out.r1 = r1;
  assign step_out.n  = n;

  // line state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r     <= HELD_NONE;
      at_start_r <= 1'b1;
      stored_r   <= '0;
      pend_r     <= '0;
    end else if (acc) begin
      held_r     <= held_nxt;
      at_start_r <= at_start_nxt;
      stored_r   <= stored_nxt;
      pend_r     <= pend_nxt;
    end
  end

`include "text_line_normalizer_assert.svh"

  // every pending space is also a stored byte of the line
  `TLN_ASSERT_ALWAYS(a_pend_le_stored, pend_r <= stored_r, "pending spaces exceed stored count")

endmodule

`default_nettype wire

>>> hw/rtl/text_line_normalizer.sv
`default_nettype none

// Text line normalizer: takes one raw byte per request and returns the kept
// bytes of normalized lines, each with the count of spaces to print before it
// and flags for line end and for the last result of the request. A request
// yields zero, one or two results, held in a two-entry result register that
// the output side drains one per cycle while ready. A new byte is taken in
// the cycle that register empties, so bytes giving at most one result flow
// at one per cycle when the output is ready, and a byte giving two results
// holds the input until its second result pops. All line logic for a byte
// sits between the line state and result registers. The user must write
// line_limit (reset 4095) via cfg_we/cfg_wdata only while idle; unchecked.
module text_line_normalizer
  import tln_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  tln_in_if.sink                 in_ch,
  tln_out_if.source              out_ch,
  input  wire logic              cfg_we,
  input  wire logic [LINE_W-1:0] cfg_wdata
);

  logic [LINE_W-1:0] line_limit_r;
  step_out_t         step_out;
  res_t              q0_r, q0_nxt;
  res_t              q1_r, q1_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic              in_acc;
  logic              out_pop;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      line_limit_r <= cfg_wdata;
    end
  end

  // take a byte once the result register drains this cycle
  assign in_ch.ready = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_ch.ready);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_pop     = out_ch.valid && out_ch.ready;

  tln_step u_step (
    .clk           (clk),
    .rst_n         (rst_n),
    .acc           (in_acc),
    .in_byte       (in_ch.in_byte),
    .end_of_stream (in_ch.end_of_stream),
    .line_limit    (line_limit_r),
    .step_out      (step_out)
  );

  // result register: load on request, shift on pop
  always_comb begin
    q0_nxt  = q0_r;
    q1_nxt  = q1_r;
    cnt_nxt = cnt_r;
    if (in_acc) begin
      q0_nxt  = step_out.r0;
      q1_nxt  = step_out.r1;
      cnt_nxt = step_out.n;
    end else if (out_pop) begin
      q0_nxt  = q1_r;
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

  // all queued results come from one request, so the tail is the last one
  assign out_ch.valid         = (cnt_r != 2'd0);
  assign out_ch.out_byte      = q0_r.byte_v;
  assign out_ch.spaces_before = q0_r.spaces;
  assign out_ch.has_byte      = q0_r.has;
  assign out_ch.end_of_line   = q0_r.eol;
  assign out_ch.last_result   = (cnt_r == 2'd1);

`include "text_line_normalizer_assert.svh"

  // a request with no result leaves the output quiet
  `TLN_ASSERT_NEXT(a_empty_req, in_acc && step_out.n == 2'd0, !out_ch.valid, "result from empty request")
  // a request with results shows its first one next cycle
  `TLN_ASSERT_NEXT(a_req_shows, in_acc && step_out.n != 2'd0, out_ch.valid, "request result missing")
  // a bare line end carries no byte and no spaces
  `TLN_ASSERT_IMPLIES(a_bare_eol, out_ch.valid && !out_ch.has_byte, out_ch.end_of_line && out_ch.spaces_before == '0 && out_ch.out_byte == '0, "malformed bare line end")

endmodule

`default_nettype wire
